/* src/ils_pkg.sv */
`timescale 1ns / 1ps

package ils_pkg;

    localparam int IDX_W  = 11;
    localparam int DATA_W = 64;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_READ   = 3'd2;
    localparam logic [2:0] CMD_WRITE  = 3'd3;
    localparam logic [2:0] CMD_FIND   = 3'd4;
    localparam logic [2:0] CMD_SUM    = 3'd5;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_INSERT,
        OP_REMOVE,
        OP_READ,
        OP_WRITE,
        OP_FIND,
        OP_SUM
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_INDEX,
        ST_FULL,
        ST_NOT_FOUND
    } status_t;

    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [IDX_W-1:0]  pos;
        logic [IDX_W-1:0]  cnt_old;
        logic [IDX_W-1:0]  cnt_new;
        status_t           status;
        logic              found;
        logic [IDX_W-1:0]  fpos;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] acc;
    } token_t;

endpackage

/* src/ils_cell.sv */
`timescale 1ns / 1ps

module ils_cell #(
    parameter int INDEX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  ils_pkg::token_t               tok_in,
    input  logic [ils_pkg::DATA_W-1:0]    nbr_data,
    output ils_pkg::token_t               tok_out,
    output logic [ils_pkg::DATA_W-1:0]    data_o
);
    import ils_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    token_t            tok_reg;
    token_t            tok_next;
    logic              below;
    logic              at_pos;
    logic              from_pos;
    logic              is_last;

    assign below    = MY_IDX < tok_in.cnt_old;
    assign at_pos   = MY_IDX == tok_in.pos;
    assign from_pos = MY_IDX >= tok_in.pos;
    assign is_last  = (MY_IDX + IDX_W'(1)) == tok_in.cnt_old;

    always_comb
    begin
        data_next = data_reg;
        tok_next  = tok_in;
        if (tok_in.valid)
        begin
            case (tok_in.op)
                OP_INSERT:
                begin
                    // swap the displaced entry into the request
                    if (from_pos && (MY_IDX <= tok_in.cnt_old))
                    begin
                        data_next    = tok_in.val;
                        tok_next.val = data_reg;
                    end
                end
                OP_REMOVE:
                begin
                    if (at_pos)
                    begin
                        tok_next.acc = data_reg;
                    end
                    if (from_pos && below)
                    begin
                        data_next = is_last ? '0 : nbr_data;
                    end
                end
                OP_READ:
                begin
                    if (at_pos)
                    begin
                        tok_next.acc = data_reg;
                    end
                end
                OP_WRITE:
                begin
                    if (at_pos)
                    begin
                        data_next = tok_in.val;
                    end
                end
                OP_FIND:
                begin
                    if (below && !tok_in.found && (data_reg == tok_in.val))
                    begin
                        tok_next.found = 1'b1;
                        tok_next.fpos  = MY_IDX;
                    end
                end
                OP_SUM:
                begin
                    if (below)
                    begin
                        tok_next.acc = tok_in.acc + data_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign data_o  = data_reg;
    assign tok_out = tok_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (en)
        begin
            tok_reg <= tok_next;
        end
    end

endmodule

/* src/indexed_list_store.sv */
`timescale 1ns / 1ps
// Requests are pipelined, and a new one can enter while earlier ones are in the chain;
// after each accepted request the input stalls for an idle slot, which lets a remove
// pull the settled entry of the next cell. Each request walks the chain one cell per
// cycle, and the chain plus output register halts on out_stall.
// Reset: fill count and all in-flight requests clear; entry contents stay
// undefined until written.
module indexed_list_store #(
    parameter int CAPACITY = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 cmd,
    input  logic [6:0]                 position,
    input  logic signed [63:0]         value_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic signed [63:0]         value_out,
    output logic [5:0]                 found_position,
    output logic [6:0]                 fill_count
);
    import ils_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 7) ? CW : 7;

    logic              en;
    logic              accept;
    logic              gap_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [PW-1:0]     pos_ext;
    logic [PW-1:0]     cnt_ext;
    token_t            tok_head;
    token_t            tok_fin;
    token_t            tok_chain [CAPACITY+1];
    logic [DATA_W-1:0] cell_data [CAPACITY+1];

    logic              out_valid_reg;
    status_t           status_reg;
    logic [DATA_W-1:0] value_reg;
    logic [5:0]        fpos_reg;
    logic [6:0]        fill_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en || gap_reg;
    assign accept   = in_valid && !in_stall;
    assign pos_ext  = PW'(position);
    assign cnt_ext  = PW'(count_reg);

    always_comb
    begin
        count_next       = count_reg;
        tok_head         = '0;
        tok_head.valid   = in_valid && !gap_reg;
        tok_head.op      = OP_NOP;
        tok_head.status  = ST_OK;
        tok_head.pos     = IDX_W'(pos_ext);
        tok_head.cnt_old = IDX_W'(count_reg);
        tok_head.val     = value_in;
        case (cmd)
            CMD_INSERT:
            begin
                if (pos_ext > cnt_ext)
                begin
                    tok_head.status = ST_BAD_INDEX;
                end
                else if (count_reg == CW'(CAPACITY))
                begin
                    tok_head.status = ST_FULL;
                end
                else
                begin
                    tok_head.op = OP_INSERT;
                    count_next  = count_reg + CW'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    tok_head.status = ST_BAD_INDEX;
                end
                else
                begin
                    tok_head.op = OP_REMOVE;
                    count_next  = count_reg - CW'(1);
                end
            end
            CMD_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    tok_head.status = ST_BAD_INDEX;
                end
                else
                begin
                    tok_head.op = OP_READ;
                end
            end
            CMD_WRITE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    tok_head.status = ST_BAD_INDEX;
                end
                else
                begin
                    tok_head.op = OP_WRITE;
                end
            end
            CMD_FIND:
            begin
                tok_head.op = OP_FIND;
            end
            CMD_SUM:
            begin
                tok_head.op = OP_SUM;
            end
            default:
            begin
            end
        endcase
        tok_head.cnt_new = IDX_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= 1'b0;
        end
        else if (en)
        begin
            gap_reg <= accept;
        end
    end

    assign tok_chain[0]        = tok_head;
    assign cell_data[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ils_cell #(
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .tok_in   (tok_chain[i]),
            .nbr_data (cell_data[i+1]),
            .tok_out  (tok_chain[i+1]),
            .data_o   (cell_data[i])
        );
    end

    assign tok_fin = tok_chain[CAPACITY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= tok_fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && tok_fin.valid)
        begin
            if (tok_fin.op == OP_FIND)
            begin
                status_reg <= tok_fin.found ? ST_OK : ST_NOT_FOUND;
            end
            else
            begin
                status_reg <= tok_fin.status;
            end
            value_reg <= tok_fin.acc;
            fpos_reg  <= tok_fin.found ? tok_fin.fpos[5:0] : 6'd0;
            fill_reg  <= tok_fin.cnt_new[6:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign value_out      = value_reg;
    assign found_position = fpos_reg;
    assign fill_count     = fill_reg;

endmodule
